@@ rtl/lpl_pkg.sv @@
// ----------------------------------------------------------------------------
// lpl_pkg: shared constants for the lookahead peak limiter
// Field widths, gain scaling, default lookahead depth and register indexes.
// ----------------------------------------------------------------------------
package lpl_pkg;

	localparam int SAMPLE_BITS       = 24;
	localparam int CEIL_W            = 23;
	localparam int GAIN_W            = 17;
	localparam int STAMP_W           = 16;
	localparam int CFG_W             = 23;
	localparam int DEF_MAX_LOOKAHEAD = 256;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

	localparam logic [2:0] REG_CEILING   = 3'd0;
	localparam logic [2:0] REG_LOOKAHEAD = 3'd1;
	localparam logic [2:0] REG_ATTACK    = 3'd2;
	localparam logic [2:0] REG_RELEASE   = 3'd3;
	localparam logic [2:0] REG_CHANNELS  = 3'd4;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

@@ rtl/lpl_ram.sv @@
// ----------------------------------------------------------------------------
// lpl_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/lpl_div.sv @@
// ----------------------------------------------------------------------------
// lpl_div: iterative gain divider
// Restoring division giving floor(num * 65536 / den) one bit per cycle,
// for num below den.
// ----------------------------------------------------------------------------
module lpl_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lpl_pkg::CEIL_W-1:0] num,
	input  logic [lpl_pkg::SAMPLE_BITS-1:0] den,
	output logic                       done,
	output logic [15:0]                quot
);
	import lpl_pkg::*;

	logic                   busy_q;
	logic [3:0]             cnt_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [15:0]            quot_q;
	logic                   done_q;
	logic [SAMPLE_BITS:0]   rem2;
	logic                   fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? SAMPLE_BITS'(rem2 - {1'b0, den_q}) : rem2[SAMPLE_BITS-1:0];
			quot_q <= {quot_q[14:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/lookahead_peak_limiter.sv @@
// ----------------------------------------------------------------------------
// lookahead_peak_limiter: lookahead brickwall peak limiter
// Frame peak to required gain, sliding-window minimum, attack/release gain
// smoothing, delay line, scaling and clamping, one frame at a time.
// ----------------------------------------------------------------------------
// Usage: a frame of two samples is a transfer on the input channel
// (in_valid high, in_stall low). One limited frame leaves on the output
// channel for every input frame, in order, together with the gain used and
// the running clamp count. The block works on one frame at a time and holds
// in_stall high while busy. A frame takes longer when the peak exceeds the
// ceiling, since the serial divider then runs, and longer again for every
// entry popped from either end of the minimum queue. The divider and the
// queue memory walk set how long a frame takes. The output sits in a
// register, so the next frame is taken while a result waits; when the
// receiver stalls with a result still held, the block waits. After reset,
// and after every write of lookahead_frames, the delay line is cleared
// while in_stall stays high; register writes are taken during that pass.
// Configuration is to be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter #(
	parameter int MAX_LOOKAHEAD = lpl_pkg::DEF_MAX_LOOKAHEAD
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [lpl_pkg::SAMPLE_BITS-1:0] sample_first,
	input  logic signed [lpl_pkg::SAMPLE_BITS-1:0] sample_second,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [lpl_pkg::SAMPLE_BITS-1:0] limited_first,
	output logic signed [lpl_pkg::SAMPLE_BITS-1:0] limited_second,
	output logic [lpl_pkg::GAIN_W-1:0]    applied_gain,
	output logic [31:0]                   clamp_count_total,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [lpl_pkg::CFG_W-1:0]     cfg_data
);
	import lpl_pkg::*;

	localparam int LA_W  = $clog2(MAX_LOOKAHEAD + 1);
	localparam int POS_W = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
	localparam int QCAP  = MAX_LOOKAHEAD + 2;
	localparam int QA_W  = $clog2(QCAP);
	localparam int QD_W  = STAMP_W + GAIN_W;
	localparam int DW    = 2 * SAMPLE_BITS;
	localparam int PW    = SAMPLE_BITS + GAIN_W + 1;
	localparam int VW    = PW - 16;

	localparam logic [3:0] S_CLR      = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DIV      = 4'd2;
	localparam logic [3:0] S_POP_RD   = 4'd3;
	localparam logic [3:0] S_POP_CHK  = 4'd4;
	localparam logic [3:0] S_PUSH     = 4'd5;
	localparam logic [3:0] S_HEAD_RD  = 4'd6;
	localparam logic [3:0] S_HEAD_CHK = 4'd7;
	localparam logic [3:0] S_DLY      = 4'd8;
	localparam logic [3:0] S_MUL      = 4'd9;
	localparam logic [3:0] S_CLP      = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	logic [3:0]        state_q;
	logic [CEIL_W-1:0] ceil_q;
	logic [8:0]        la_q;
	logic [GAIN_W-1:0] atk_q;
	logic [GAIN_W-1:0] rel_q;
	logic [1:0]        act_q;

	logic [POS_W-1:0]   clr_q;
	logic [POS_W-1:0]   pos_q;
	logic [QA_W-1:0]    head_q;
	logic [QA_W-1:0]    tail_q;
	logic [STAMP_W-1:0] fc_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [31:0]        clamp_q;
	logic               lane_q;
	logic               out_valid_q;

	sample_t           s0_q;
	sample_t           s1_q;
	logic [GAIN_W-1:0] need_q;
	logic [DW-1:0]     dly_q;
	logic signed [PW-1:0] prod_q;
	sample_t           res0_q;
	sample_t           res1_q;
	sample_t           out0_q;
	sample_t           out1_q;
	logic [GAIN_W-1:0] out_gain_q;
	logic [31:0]       out_cnt_q;

	logic                   two_ch;
	logic [31:0]            look_raw;
	logic [31:0]            look_sel;
	logic [LA_W-1:0]        look;
	logic [POS_W-1:0]       pos_eff;
	logic [31:0]            pos_inc;
	logic [SAMPLE_BITS-1:0] abs0;
	logic [SAMPLE_BITS-1:0] abs1;
	logic [SAMPLE_BITS-1:0] peak;
	logic                   over;
	logic                   in_xfer;
	logic                   div_done;
	logic [15:0]            div_quot;
	logic [QA_W-1:0]        tail_dec;
	logic [QA_W-1:0]        tail_inc;
	logic [QA_W-1:0]        head_inc;
	logic                   q_we;
	logic [QA_W-1:0]        q_raddr;
	logic [QD_W-1:0]        q_rdata;
	logic [GAIN_W-1:0]      q_gain;
	logic [STAMP_W-1:0]     q_age;
	logic                   d_we;
	logic [POS_W-1:0]       d_waddr;
	logic [DW-1:0]          d_wdata;
	logic [DW-1:0]          d_rdata;
	logic [SAMPLE_BITS-1:0] d_lane1;
	logic signed [GAIN_W+1:0] g_dn;
	logic [GAIN_W:0]        g_up;
	logic [GAIN_W-1:0]      gain_nx;
	sample_t                mul_in;
	logic signed [PW-1:0]   prod_r;
	logic signed [VW-1:0]   v;
	logic signed [VW-1:0]   cv;
	sample_t                clp;
	logic                   clipped;
	logic                   out_free;

	assign two_ch   = act_q[1];
	assign look_raw = {23'd0, la_q};
	assign look_sel = (la_q == 9'd0) ? 32'd1 :
	                  ((look_raw > 32'(MAX_LOOKAHEAD)) ? 32'(MAX_LOOKAHEAD) : look_raw);
	assign look     = look_sel[LA_W-1:0];
	assign pos_eff  = (32'(pos_q) >= 32'(look)) ? '0 : pos_q;
	assign pos_inc  = 32'(pos_eff) + 32'd1;

	assign abs0 = sample_first[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_first) : sample_first;
	assign abs1 = (two_ch && sample_second[SAMPLE_BITS-1]) ? SAMPLE_BITS'(-sample_second) :
	              (two_ch ? sample_second : '0);
	assign peak = (abs1 > abs0) ? abs1 : abs0;
	assign over = peak > {1'b0, ceil_q};

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	lpl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer && over),
		.num    (ceil_q),
		.den    (peak),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign tail_dec = (tail_q == '0) ? QA_W'(QCAP - 1) : QA_W'(tail_q - 1'b1);
	assign tail_inc = (tail_q == QA_W'(QCAP - 1)) ? '0 : QA_W'(tail_q + 1'b1);
	assign head_inc = (head_q == QA_W'(QCAP - 1)) ? '0 : QA_W'(head_q + 1'b1);
	assign q_we     = (state_q == S_PUSH);
	assign q_raddr  = (state_q == S_POP_RD) ? tail_dec : head_q;
	assign q_gain   = q_rdata[GAIN_W-1:0];
	assign q_age    = STAMP_W'(fc_q - q_rdata[QD_W-1:GAIN_W]);

	lpl_ram #(.WIDTH(QD_W), .DEPTH(QCAP)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata ({fc_q, need_q}),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	assign d_we    = (state_q == S_CLR) || (state_q == S_DLY);
	assign d_waddr = (state_q == S_CLR) ? clr_q : pos_eff;
	assign d_lane1 = two_ch ? s1_q : d_rdata[DW-1:SAMPLE_BITS];
	assign d_wdata = (state_q == S_CLR) ? '0 : {d_lane1, s0_q};

	lpl_ram #(.WIDTH(DW), .DEPTH(MAX_LOOKAHEAD)) u_delay (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (pos_eff),
		.rdata (d_rdata)
	);

	assign g_dn = $signed({2'b00, gain_q}) - $signed({2'b00, atk_q});
	assign g_up = {1'b0, gain_q} + {1'b0, rel_q};
	always_comb begin
		if (q_gain < gain_q) begin
			gain_nx = (g_dn > $signed({2'b00, q_gain})) ? g_dn[GAIN_W-1:0] : q_gain;
		end else begin
			gain_nx = (g_up < {1'b0, q_gain}) ? g_up[GAIN_W-1:0] : q_gain;
		end
	end

	assign mul_in  = lane_q ? dly_q[DW-1:SAMPLE_BITS] : dly_q[SAMPLE_BITS-1:0];
	assign prod_r  = PW'(mul_in) * $signed({1'b0, gain_q});
	assign v       = VW'((prod_q + PW'(32768)) >>> 16);
	assign cv      = $signed(VW'({1'b0, ceil_q}));
	assign clipped = (v > cv) || (v < -cv);
	assign clp     = (v > cv) ? SAMPLE_BITS'(cv) :
	                 ((v < -cv) ? SAMPLE_BITS'(-cv) : SAMPLE_BITS'(v));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ceil_q      <= 23'd1037000;
			la_q        <= 9'd240;
			atk_q       <= 17'd273;
			rel_q       <= 17'd14;
			act_q       <= 2'd2;
			clr_q       <= '0;
			pos_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fc_q        <= '0;
			gain_q      <= UNITY_GAIN;
			clamp_q     <= '0;
			lane_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= POS_W'(clr_q + 1'b1);
					if (32'(clr_q) == 32'(MAX_LOOKAHEAD - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= over ? S_DIV : S_POP_RD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: begin
					state_q <= (tail_q == head_q) ? S_PUSH : S_POP_CHK;
				end
				S_POP_CHK: begin
					if (q_gain >= need_q) begin
						tail_q  <= tail_dec;
						state_q <= S_POP_RD;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					tail_q  <= tail_inc;
					state_q <= S_HEAD_RD;
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_CHK;
				end
				S_HEAD_CHK: begin
					if (32'(q_age) > 32'(look)) begin
						head_q  <= head_inc;
						state_q <= S_HEAD_RD;
					end else begin
						gain_q  <= gain_nx;
						fc_q    <= STAMP_W'(fc_q + 1'b1);
						state_q <= S_DLY;
					end
				end
				S_DLY: begin
					pos_q   <= (pos_inc == 32'(look)) ? '0 : POS_W'(pos_inc);
					lane_q  <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_CLP;
				end
				S_CLP: begin
					if (clipped && clamp_q != 32'hFFFF_FFFF) begin
						clamp_q <= clamp_q + 32'd1;
					end
					if (!lane_q && two_ch) begin
						lane_q  <= 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					REG_CEILING:   ceil_q <= cfg_data[CEIL_W-1:0];
					REG_LOOKAHEAD: begin
						la_q    <= cfg_data[8:0];
						clr_q   <= '0;
						pos_q   <= '0;
						head_q  <= '0;
						tail_q  <= '0;
						fc_q    <= '0;
						state_q <= S_CLR;
					end
					REG_ATTACK:    atk_q <= cfg_data[GAIN_W-1:0];
					REG_RELEASE:   rel_q <= cfg_data[GAIN_W-1:0];
					REG_CHANNELS:  act_q <= cfg_data[1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s0_q   <= sample_first;
			s1_q   <= sample_second;
			res1_q <= '0;
			need_q <= UNITY_GAIN;
		end
		if (state_q == S_DIV && div_done) begin
			need_q <= {1'b0, div_quot};
		end
		if (state_q == S_DLY) begin
			dly_q <= d_rdata;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_r;
		end
		if (state_q == S_CLP) begin
			if (lane_q) begin
				res1_q <= clp;
			end else begin
				res0_q <= clp;
			end
		end
		if (state_q == S_DONE && out_free) begin
			out0_q     <= res0_q;
			out1_q     <= res1_q;
			out_gain_q <= gain_q;
			out_cnt_q  <= clamp_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign limited_first     = out0_q;
	assign limited_second    = out1_q;
	assign applied_gain      = out_gain_q;
	assign clamp_count_total = out_cnt_q;

`ifndef NO_ASSERTIONS
	a_gain_unity: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY_GAIN)
		else $error("gain above unity");

	a_queue_newest_kept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HEAD_CHK && head_inc == tail_q |-> 32'(q_age) <= 32'(look))
		else $error("newest queue entry aged out");

	a_clamp_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 clamp_q >= $past(clamp_q))
		else $error("clamp count decreased");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_cnt_q))
		else $error("stalled result changed");
`endif

endmodule
